>>> hdl/grouped_free_block_list_allocator_core_defines.svh
// Assertion macros used by the grouped free-block list allocator datapath.
// No dependencies; expects clk and rst in the scope of each use.
`ifndef GROUPED_FREE_BLOCK_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define GROUPED_FREE_BLOCK_LIST_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define GFBL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GFBL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/gfbl_pkg.sv
// Types and constants of the grouped free-block list allocator.
// No dependencies; imported by the controller, datapath and top level.
package gfbl_pkg;

  localparam int BLK_W = 10;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_LOAD,
    S_LOAD_END,
    S_SPILL,
    S_SPILL_END
  } state_t;

  typedef enum logic [2:0] {
    RPL_NONE,
    RPL_ZERO,
    RPL_EXHAUST,
    RPL_POP,
    RPL_HOLD
  } reply_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    logic   load_start;
    logic   spill_start;
    logic   sweep;
    logic   load_end;
    logic   spill_end;
    reply_t reply;
  } ctl_t;

  typedef struct packed {
    logic cmd_free;
    logic blk_ok;
    logic full;
    logic low;
    logic link_ok;
    logic last;
  } st_t;

endpackage

>>> hdl/grouped_free_block_list_allocator_core.sv
// Top level of the grouped free-block list allocator.
// Depends on gfbl_pkg, gfbl_ctrl, gfbl_dp (and through it gfbl_ram).
//
// Hands out and takes back block numbers with the classic grouped free list.
// A request (cmd 0 allocate, cmd 1 free block_number) is taken at a rising
// edge where start is high and busy is low. Every request gives exactly one
// result: granted_block and status valid for the single cycle in which done
// is high. The receiver cannot stall, so sample them on that cycle. Status 1
// means the list is exhausted (granted_block is 0); a free always answers 0/0,
// and a free of block 0 or of a block at or above NUM_BLOCKS is ignored.
// Double frees are not detected. Reset leaves an empty list; free blocks to
// populate it. Path from the accepting edge to done: a free that fits in the
// cached group, or an ignored free, or an exhausted allocate shows done in
// the next cycle and busy never rises; a plain allocate pops the top slot
// from the slot RAM and passes through S_POP, from which done is registered;
// an allocate that takes the link block, or a free into a full group, sweeps
// GROUP_SIZE slots through the group store one slot per cycle, and done is
// registered from the closing S_LOAD_END or S_SPILL_END state. No clearing
// pass is needed after reset: the link slot lives in a register and the
// stores are read only after a spill has written them.
module grouped_free_block_list_allocator_core #(
  parameter int NUM_BLOCKS = 1024,
  parameter int GROUP_SIZE = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       cmd,
  input  logic [9:0] block_number,
  output logic       done,
  output logic [9:0] granted_block,
  output logic       status
);
  import gfbl_pkg::*;

  ctl_t ctl;   // controller -> datapath commands
  st_t  st;    // datapath -> controller status

  gfbl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .ctl   (ctl),
    .busy  (busy)
  );

  gfbl_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .GROUP_SIZE (GROUP_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .block_number  (block_number),
    .ctl           (ctl),
    .st            (st),
    .granted_block (granted_block),
    .status        (status),
    .done          (done)
  );

endmodule

>>> hdl/gfbl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gfbl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/gfbl_ctrl.sv
// Controller state machine of the grouped free-block list allocator.
// Depends on gfbl_pkg (state, command and status types).
module gfbl_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  gfbl_pkg::st_t  st,
  output gfbl_pkg::ctl_t ctl,
  output logic         busy
);
  import gfbl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (st.cmd_free) begin
            if (st.blk_ok && st.full) begin
              state_next = S_SPILL;
            end
          end else if (!st.low) begin
            state_next = S_POP;
          end else if (st.link_ok) begin
            state_next = S_LOAD;
          end
        end
      end
      S_POP:       state_next = S_IDLE;
      S_LOAD: begin
        if (st.last) begin
          state_next = S_LOAD_END;
        end
      end
      S_LOAD_END:  state_next = S_IDLE;
      S_SPILL: begin
        if (st.last) begin
          state_next = S_SPILL_END;
        end
      end
      S_SPILL_END: state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl  = '0;
    ctl.reply = RPL_NONE;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          if (st.cmd_free) begin
            if (!st.blk_ok) begin
              ctl.reply = RPL_ZERO;
            end else if (!st.full) begin
              ctl.push  = 1'b1;
              ctl.reply = RPL_ZERO;
            end else begin
              ctl.spill_start = 1'b1;
            end
          end else if (!st.low) begin
            ctl.pop = 1'b1;
          end else if (!st.link_ok) begin
            ctl.reply = RPL_EXHAUST;
          end else begin
            ctl.load_start = 1'b1;
          end
        end
      end
      S_POP:  ctl.reply = RPL_POP;
      S_LOAD: ctl.sweep = 1'b1;
      S_LOAD_END: begin
        ctl.load_end = 1'b1;
        ctl.reply    = RPL_HOLD;
      end
      S_SPILL: ctl.sweep = 1'b1;
      S_SPILL_END: begin
        ctl.spill_end = 1'b1;
        ctl.reply     = RPL_ZERO;
      end
      default: ctl = '0;
    endcase
  end

endmodule

>>> hdl/gfbl_dp.sv
// Datapath of the grouped free-block list allocator: link, count, slot RAM,
// group store RAMs and result registers. Depends on gfbl_pkg and gfbl_ram.
`include "grouped_free_block_list_allocator_core_defines.svh"

module gfbl_dp #(
  parameter int NUM_BLOCKS = 1024,
  parameter int GROUP_SIZE = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd,
  input  logic [gfbl_pkg::BLK_W-1:0] block_number,
  input  gfbl_pkg::ctl_t             ctl,
  output gfbl_pkg::st_t              st,
  output logic [gfbl_pkg::BLK_W-1:0] granted_block,
  output logic                       status,
  output logic                       done
);
  import gfbl_pkg::*;

  localparam int CNT_W = $clog2(GROUP_SIZE + 1);
  localparam int CI_W  = $clog2(GROUP_SIZE);
  localparam int NB_W  = $clog2(NUM_BLOCKS);
  localparam int SA_W  = $clog2(NUM_BLOCKS * GROUP_SIZE);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(GROUP_SIZE);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CI_W-1:0]  IDX_LAST = CI_W'(GROUP_SIZE - 1);

  logic [BLK_W-1:0] link;      // slot 1
  logic [CNT_W-1:0] count;
  logic [BLK_W-1:0] req_blk;   // block whose store entry is swept
  logic [SA_W-1:0]  saddr;
  logic [SA_W-1:0]  saddr_d;
  logic [CI_W-1:0]  idx;
  logic [CI_W-1:0]  pipe_idx;
  logic             pipe_vld;
  logic             spill_mode;

  logic             c_we;
  logic [CI_W-1:0]  c_waddr;
  logic [BLK_W-1:0] c_wdata;
  logic [CI_W-1:0]  c_raddr;
  logic [BLK_W-1:0] c_rdata;
  logic             s_we;
  logic [BLK_W-1:0] s_wdata;
  logic [BLK_W-1:0] s_rdata;
  logic [CNT_W-1:0] n_rdata;
  logic             load_wr;

  // status
  always_comb begin
    st.cmd_free = (cmd == CMD_FREE);
    st.blk_ok   = (block_number != '0) && (32'(block_number) < NUM_BLOCKS);
    st.full     = (count >= CNT_FULL);
    st.low      = (count <= CNT_ONE);
    st.link_ok  = (link != '0) && (32'(link) < NUM_BLOCKS);
    st.last     = (idx == IDX_LAST);
  end

  assign load_wr = pipe_vld && !spill_mode;

  // slot RAM holds slots 2..GROUP_SIZE at addresses 1..GROUP_SIZE-1
  always_comb begin
    c_raddr = ctl.pop ? CI_W'(count - CNT_ONE) : idx;
    c_we    = 1'b0;
    c_waddr = pipe_idx;
    c_wdata = s_rdata;
    if (load_wr && pipe_idx != '0) begin
      c_we = 1'b1;
    end else if (ctl.push && count != '0) begin
      c_we    = 1'b1;
      c_waddr = CI_W'(count);
      c_wdata = block_number;
    end
  end

  assign s_we    = pipe_vld && spill_mode;
  assign s_wdata = (pipe_idx == '0) ? link : c_rdata;

  gfbl_ram #(.WIDTH(BLK_W), .DEPTH(GROUP_SIZE)) u_slots (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  gfbl_ram #(.WIDTH(BLK_W), .DEPTH(NUM_BLOCKS * GROUP_SIZE)) u_group_store (
    .clk   (clk),
    .we    (s_we),
    .waddr (saddr_d),
    .wdata (s_wdata),
    .raddr (saddr),
    .rdata (s_rdata)
  );

  gfbl_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BLOCKS)) u_count_store (
    .clk   (clk),
    .we    (ctl.spill_end),
    .waddr (NB_W'(req_blk)),
    .wdata (CNT_FULL),
    .raddr (NB_W'(req_blk)),
    .rdata (n_rdata)
  );

  // sweep bookkeeping
  always_ff @(posedge clk) begin
    if (ctl.load_start) begin
      req_blk <= link;
      saddr   <= SA_W'(32'(link) * 32'(GROUP_SIZE));
      idx     <= '0;
    end else if (ctl.spill_start) begin
      req_blk <= block_number;
      saddr   <= SA_W'(32'(block_number) * 32'(GROUP_SIZE));
      idx     <= '0;
    end else if (ctl.sweep) begin
      saddr <= saddr + SA_W'(1);
      idx   <= idx + CI_W'(1);
    end
    if (ctl.sweep) begin
      saddr_d  <= saddr;
      pipe_idx <= idx;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      link       <= '0;
      count      <= CNT_ONE;
      pipe_vld   <= 1'b0;
      spill_mode <= 1'b0;
      done       <= 1'b0;
    end else begin
      pipe_vld <= ctl.sweep;
      done     <= (ctl.reply != RPL_NONE);
      if (ctl.load_start) begin
        spill_mode <= 1'b0;
      end else if (ctl.spill_start) begin
        spill_mode <= 1'b1;
      end

      if (load_wr && pipe_idx == '0) begin
        link <= s_rdata;
      end else if (ctl.push && count == '0) begin
        link <= block_number;
      end else if (ctl.spill_end) begin
        link <= req_blk;
      end

      if (ctl.push) begin
        count <= count + CNT_ONE;
      end else if (ctl.pop) begin
        count <= count - CNT_ONE;
      end else if (ctl.load_end) begin
        count <= (n_rdata > CNT_FULL) ? CNT_FULL : n_rdata;
      end else if (ctl.spill_end) begin
        count <= CNT_ONE;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (ctl.load_start) begin
      granted_block <= link;
    end
    case (ctl.reply)
      RPL_ZERO: begin
        granted_block <= '0;
        status        <= 1'b0;
      end
      RPL_EXHAUST: begin
        granted_block <= '0;
        status        <= 1'b1;
      end
      RPL_POP: begin
        granted_block <= c_rdata;
        status        <= 1'b0;
      end
      RPL_HOLD: status <= 1'b0;
      default: ;
    endcase
  end

  `GFBL_ASSERT_NOW(a_count_range, 1'b1, count <= CNT_FULL, "slot count above group size")
  `GFBL_ASSERT_NOW(a_exhaust_zero, done && status, granted_block == '0, "exhausted with block")
  `GFBL_ASSERT_NEXT(a_spill_link, ctl.spill_end, count == CNT_ONE && link == $past(req_blk),
    "spill did not install new link")

endmodule

>>> tb/grouped_free_block_list_allocator_core_test.sv
`timescale 1ns / 1ps
// Self-checking test of grouped_free_block_list_allocator_core.
// Depends on gfbl_pkg for the command codes and block width; keeps its own free-list model and
// compares every reply, then drives directed and random allocate/free requests.
module grouped_free_block_list_allocator_core_test;

  localparam int NUM_BLOCKS = 1024;
  localparam int GROUP_SIZE = 16;
  localparam int BLK_W      = gfbl_pkg::BLK_W;

  // Status codes and the end-of-chain mark.
  localparam logic             STATUS_OK        = 1'b0;
  localparam logic             STATUS_EXHAUSTED = 1'b1;
  localparam logic [BLK_W-1:0] END_OF_CHAIN     = '0;
  localparam logic [BLK_W-1:0] TOP_BLOCK        = '1;

  // Worst request is a group sweep; pad a bit past it before the final verdict.
  localparam int DRAIN_CYCLES = GROUP_SIZE + 8;
  localparam int RANDOM_REQS  = 1650;

  typedef struct packed {
    logic [BLK_W-1:0] granted;
    logic             status;
  } grant_reply_t;

  // ------------------------------------------------------------------------
  // Free-list tracker: mirrors the cached group and the spilled groups, and
  // holds the replies still owed by the DUT, oldest first.
  // ------------------------------------------------------------------------
  class free_list_tracker;
    logic [GROUP_SIZE-1:0][BLK_W-1:0] group_slots;   // slot k at index k-1
    int unsigned                      group_fill;
    logic [GROUP_SIZE-1:0][BLK_W-1:0] spilled_groups [NUM_BLOCKS];
    int unsigned                      spilled_fill   [NUM_BLOCKS];
    grant_reply_t                     owed_replies[$];
    int unsigned                      live_blocks;   // free blocks held (rough)
    logic [BLK_W-1:0]                 last_grant;
    int unsigned                      errors;

    function new();
      group_slots = '0;
      group_fill  = 1;             // link slot only, holding end of chain
      live_blocks = 0;
      last_grant  = END_OF_CHAIN;
      errors      = 0;
    endfunction

    // Advance the model by one accepted request and queue its reply.
    function void note_request(logic req_cmd, logic [BLK_W-1:0] blk);
      grant_reply_t r;
      r.granted = END_OF_CHAIN;
      r.status  = STATUS_OK;
      if (req_cmd == gfbl_pkg::CMD_ALLOC) begin
        if (group_fill <= 1) begin
          // Only the link is left: grant it and pull in the group it stores.
          if (group_slots[0] == END_OF_CHAIN || group_slots[0] >= NUM_BLOCKS) begin
            r.status = STATUS_EXHAUSTED;
          end else begin
            r.granted   = group_slots[0];
            group_slots = spilled_groups[r.granted];
            group_fill  = spilled_fill[r.granted];
            if (group_fill > GROUP_SIZE) group_fill = GROUP_SIZE;
          end
        end else begin
          if (group_fill > GROUP_SIZE) group_fill = GROUP_SIZE;
          r.granted  = group_slots[group_fill-1];
          group_fill = group_fill - 1;
        end
        if (r.status == STATUS_OK) begin
          if (live_blocks > 0) live_blocks--;
          last_grant = r.granted;
        end
      end else if (blk != END_OF_CHAIN && blk < NUM_BLOCKS) begin
        if (group_fill >= GROUP_SIZE) begin
          // Full group moves into the freed block, which becomes the link.
          spilled_groups[blk] = group_slots;
          spilled_fill[blk]   = GROUP_SIZE;
          group_slots         = '0;
          group_slots[0]      = blk;
          group_fill          = 1;
        end else begin
          group_fill                = group_fill + 1;
          group_slots[group_fill-1] = blk;
        end
        live_blocks++;
      end
      owed_replies.push_back(r);
    endfunction

    function void check_reply(logic [BLK_W-1:0] granted, logic status);
      grant_reply_t want;
      if (owed_replies.size() == 0) begin
        $error("reply with none owed: granted_block %0d status %0d", granted, status);
        errors++;
        return;
      end
      want = owed_replies.pop_front();
      if (granted !== want.granted) begin
        $error("granted_block: expected %0d, got %0d", want.granted, granted);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
    endfunction

    function int unsigned owed();
      return owed_replies.size();
    endfunction
  endclass

  // ------------------------------------------------------------------------
  // DUT hookup
  // ------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             cmd = gfbl_pkg::CMD_ALLOC;
  logic [BLK_W-1:0] block_number = '0;
  logic             done;
  logic [BLK_W-1:0] granted_block;
  logic             status;

  free_list_tracker tracker = new();

  grouped_free_block_list_allocator_core #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .GROUP_SIZE(GROUP_SIZE)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .block_number (block_number),
    .done         (done),
    .granted_block(granted_block),
    .status       (status)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Replies last exactly one cycle and cannot be held off; take them at the
  // edge that closes the done cycle.
  always @(posedge clk) begin
    if (!rst && done) tracker.check_reply(granted_block, status);
  end

  // ------------------------------------------------------------------------
  // Request driving: inputs move on the falling edge, the handshake is seen
  // on the rising edge (start high, busy low).
  // ------------------------------------------------------------------------
  task automatic issue(input logic req_cmd, input logic [BLK_W-1:0] blk);
    @(negedge clk);
    start        = 1'b1;
    cmd          = req_cmd;
    block_number = blk;
    do @(posedge clk); while (busy);
    tracker.note_request(req_cmd, blk);
  endtask

  // Drop start for the requested gap; payload wanders meanwhile and must be ignored.
  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk);
      start        = 1'b0;
      cmd          = 1'($urandom);
      block_number = BLK_W'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(99, 0);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Freed block: mostly random, some extremes, some re-frees of a recent grant
  // (double frees are legal and simply pushed again).
  function automatic logic [BLK_W-1:0] pick_block();
    int r;
    r = $urandom_range(99, 0);
    if (r < 4)  return END_OF_CHAIN;
    if (r < 8)  return TOP_BLOCK;
    if (r < 11) return BLK_W'(1);
    if (r < 25) return tracker.last_grant;
    return BLK_W'($urandom_range(NUM_BLOCKS - 1, 1));
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  initial begin
    int  free_pct;
    bit  burst;
    logic [BLK_W-1:0] fill_blocks [GROUP_SIZE];

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty list, ignored free, fill the group, spill, link reload.
    issue(gfbl_pkg::CMD_ALLOC, TOP_BLOCK);       // exhausted on an empty list
    idle_for(pick_gap(1'b0));
    issue(gfbl_pkg::CMD_FREE, END_OF_CHAIN);     // block 0 is never freed
    fill_blocks = '{10'h3FF, 10'h001, 10'h155, 10'h2AA, 10'h200, 10'h100, 10'h080,
                    10'h040, 10'h020, 10'h010, 10'h008, 10'h004, 10'h002, 10'h1FF,
                    10'h3FE, 10'h123};
    // The first GROUP_SIZE-1 fill the cached group; the last one spills it.
    foreach (fill_blocks[i]) begin
      issue(gfbl_pkg::CMD_FREE, fill_blocks[i]);
      idle_for(pick_gap(i < 8));
    end
    issue(gfbl_pkg::CMD_ALLOC, END_OF_CHAIN);    // grants the link, reloads
    issue(gfbl_pkg::CMD_ALLOC, TOP_BLOCK);       // plain pop
    issue(gfbl_pkg::CMD_FREE, 10'h2AA);          // double free of a block already on the list
    issue(gfbl_pkg::CMD_FREE, 10'h2AA);
    issue(gfbl_pkg::CMD_ALLOC, END_OF_CHAIN);

    // Random: phases with different free/allocate mixes so the list both
    // grows through many spills and drains down to exhaustion.
    free_pct = 50;
    burst    = 1'b0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 120 == 0) begin
        case ($urandom_range(5, 0))
          0:       free_pct = 15;
          1:       free_pct = 85;
          2:       free_pct = 30;
          3:       free_pct = 70;
          default: free_pct = 50;
        endcase
      end
      if (n % 40 == 0) burst = ($urandom_range(3, 0) == 0);
      // Keep the list from growing without bound, mostly.
      if (tracker.live_blocks > 400 && free_pct > 50) free_pct = 30;
      if ($urandom_range(99, 0) < free_pct) begin
        issue(gfbl_pkg::CMD_FREE, pick_block());
      end else begin
        issue(gfbl_pkg::CMD_ALLOC, BLK_W'($urandom));
      end
      idle_for(pick_gap(burst));
    end

    @(negedge clk);
    start = 1'b0;
    while (tracker.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
